/* rtl/mst_pkg.sv */
// Shared constants, codes and byte-class helpers for the MessagePack stream tokeniser.
// No dependencies; compiled first.
`default_nettype none
package mst_pkg;

	localparam int DEF_MAX_DEPTH = 16;
	localparam int CNT_W = 33;

	// token kinds
	localparam logic [3:0] TK_ARRAY = 4'd0;
	localparam logic [3:0] TK_MAP   = 4'd1;
	localparam logic [3:0] TK_NIL   = 4'd2;
	localparam logic [3:0] TK_BOOL  = 4'd3;
	localparam logic [3:0] TK_INT   = 4'd4;
	localparam logic [3:0] TK_UINT  = 4'd5;
	localparam logic [3:0] TK_F32   = 4'd6;
	localparam logic [3:0] TK_F64   = 4'd7;
	localparam logic [3:0] TK_STR   = 4'd8;
	localparam logic [3:0] TK_BIN   = 4'd9;
	localparam logic [3:0] TK_PAY   = 4'd10;
	localparam logic [3:0] TK_ERROR = 4'd11;

	// error codes
	localparam logic [3:0] E_NONE    = 4'd0;
	localparam logic [3:0] E_TOP     = 4'd1;
	localparam logic [3:0] E_DEEP    = 4'd2;
	localparam logic [3:0] E_VAL     = 4'd3;
	localparam logic [3:0] E_KEY     = 4'd4;
	localparam logic [3:0] E_WIDE    = 4'd5;
	localparam logic [3:0] E_NAN     = 4'd6;
	localparam logic [3:0] E_EARLY   = 4'd7;
	localparam logic [3:0] E_STRLEN  = 4'd8;

	// configuration register indexes
	localparam logic [1:0] CFG_DEPTH_LIMIT = 2'd0;
	localparam logic [1:0] CFG_WIDE_KEYS   = 2'd1;
	localparam logic [1:0] CFG_CAP_STR     = 2'd2;

	typedef struct packed {
		logic             clear;
		logic             push;
		logic             push_map;
		logic [CNT_W-1:0] push_cnt;
		logic             complete;
	} stk_cmd_t;

	function automatic logic is_container(input logic [7:0] t);
		return (t inside {[8'h80:8'h9f], [8'hdc:8'hdf]});
	endfunction

	function automatic logic is_wide_str(input logic [7:0] t);
		return (t == 8'hc6) || (t == 8'hdb);
	endfunction

	function automatic logic key_ok(input logic [7:0] t);
		return (t inside {[8'h00:8'h7f], [8'he0:8'hff], [8'ha0:8'hbf], 8'hc4, 8'hc5,
			8'hd9, 8'hda, 8'hca, 8'hcb, [8'hcc:8'hcf]});
	endfunction

	function automatic logic supported(input logic [7:0] t);
		return !(t inside {8'hc1, [8'hc7:8'hc9], [8'hd4:8'hd8]});
	endfunction

	function automatic logic [3:0] header_len(input logic [7:0] t);
		logic [3:0] r;
		r = 4'd0;
		case (t) inside
			8'hc4, 8'hd9:                      r = 4'd1;
			8'hc5, 8'hda, 8'hdc, 8'hde:        r = 4'd2;
			8'hc6, 8'hdb, 8'hdd, 8'hdf, 8'hca: r = 4'd4;
			8'hcb:                             r = 4'd8;
			[8'hcc:8'hcf], [8'hd0:8'hd3]:      r = 4'(4'd1 << t[1:0]);
			default:                           r = 4'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/mst_if.sv */
// Valid/ready channel interfaces for encoded bytes in and tokens out.
// Depends on nothing.
`default_nettype none
interface mst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       first_byte;
	logic       last_byte;
	modport source(output valid, in_byte, first_byte, last_byte, input ready);
	modport sink(input valid, in_byte, first_byte, last_byte, output ready);
endinterface

interface mst_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [63:0] token_value;
	logic        in_key_slot;
	logic [4:0]  nest_level;
	logic [4:0]  closes_after;
	logic [3:0]  error_code;
	logic        message_done;
	modport source(output valid, token_kind, token_value, in_key_slot, nest_level,
		closes_after, error_code, message_done, input ready);
	modport sink(input valid, token_kind, token_value, in_key_slot, nest_level,
		closes_after, error_code, message_done, output ready);
endinterface
`default_nettype wire

/* rtl/mst_stack.sv */
// Nesting stack of remaining element counts with one-step close cascade.
// Depends on mst_pkg.
`default_nettype none
module mst_stack import mst_pkg::*; #(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH,
	parameter int SPW       = $clog2(MAX_DEPTH + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire stk_cmd_t       cmd,
	output logic [SPW-1:0]      sp,
	output logic [SPW-1:0]      sp_next,
	output logic [SPW-1:0]      casc_sp,
	output logic                key_slot
);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [SPW-1:0]   sp_q;
	logic [CNT_W-1:0] cnt_q [MAX_DEPTH];
	logic             map_q [MAX_DEPTH];
	logic [IW-1:0]    top_idx;
	logic [IW-1:0]    dec_idx;

	assign sp      = cmd.clear ? '0 : sp_q;
	assign top_idx = IW'(sp - SPW'(1));
	assign dec_idx = IW'(casc_sp - SPW'(1));
	assign key_slot = (sp != '0) && map_q[top_idx] && !cnt_q[top_idx][0];

	// highest open level whose count is not one stays open; all above close
	always_comb begin
		casc_sp = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if ((SPW'(i) < sp) && (cnt_q[i] != CNT_W'(1)))
				casc_sp = SPW'(i + 1);
		end
	end

	always_comb begin
		if (cmd.push)
			sp_next = sp + SPW'(1);
		else if (cmd.complete)
			sp_next = casc_sp;
		else
			sp_next = sp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sp_q <= '0;
		else
			sp_q <= sp_next;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			cnt_q[IW'(sp)] <= cmd.push_cnt;
			map_q[IW'(sp)] <= cmd.push_map;
		end else if (cmd.complete && casc_sp != '0) begin
			cnt_q[dec_idx] <= cnt_q[dec_idx] - CNT_W'(1);
		end
	end
endmodule
`default_nettype wire

/* rtl/msgpack_stream_tokenizer.sv */
// Top level of the MessagePack stream tokeniser: byte decode, header assembly, token register.
// Depends on mst_pkg, mst_if (mst_in_if, mst_tok_if) and mst_stack.
//
// Usage: encoded bytes arrive on in_ch, one per transaction, with first_byte marking the
// start of a message (it restarts the parse) and last_byte the end of the buffer. Tokens
// leave on tok_ch: one per container header, scalar, string/binary header, payload byte or
// error. Header bytes of multi-byte items give no token until the header is complete.
// Throughput: one byte per cycle unless a full output register stalls intake. A token
// appears on tok_ch the cycle after the byte that caused it is taken, from the single output
// register; the close cascade is a priority encode over the stack counts in the same cycle.
// in_ch.ready is high whenever the output register is empty or being drained, so a
// stalled receiver holds the token and stops intake only while the register is full.
// Reset (arst_n low) empties the output register, clears the stack pointer and puts the
// parser idle; bytes without first_byte are then ignored. After an error token or a
// completed message the parser waits for the next first_byte.
// Configuration (cfg_we/cfg_index/cfg_data) is written only while idle by the user; the block
// does not enforce it. Index 0 is the depth limit, 1 allows wide keys, 2 caps string lengths.
`default_nettype none
module msgpack_stream_tokenizer import mst_pkg::*; #(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mst_in_if.sink          in_ch,
	mst_tok_if.source       tok_ch,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [4:0] cfg_data
);
	localparam int SPW = $clog2(MAX_DEPTH + 1);
	localparam int CW  = ((SPW > 5) ? SPW : 5) + 1;

	typedef enum logic [2:0] {
		PH_IDLE, PH_TYPE, PH_HDR, PH_PAY, PH_DONE, PH_ERR
	} phase_t;

	// configuration
	logic [4:0] depth_limit_q;
	logic       wide_keys_q;
	logic       cap_str_q;

	// parse state
	phase_t      phase_q, phase_n;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  left_q, left_n;
	logic [7:0]  ptype_q, ptype_n;
	logic [31:0] pay_q, pay_n;

	// token register
	logic        tok_v_q;
	logic [3:0]  kind_q;
	logic [63:0] val_q;
	logic        key_q;
	logic [4:0]  lvl_q;
	logic [4:0]  closes_q;
	logic [3:0]  err_q;
	logic        done_q;

	// stack
	stk_cmd_t        cmd;
	logic [SPW-1:0]  sp_eff, sp_next, casc_sp;
	logic            key_slot;

	logic        fire, active, in_rdy;
	logic [7:0]  b;
	phase_t      ph_eff;

	// per-byte decode
	logic        emit;
	logic [3:0]  kind;
	logic [63:0] val;
	logic        key;
	logic [4:0]  lvl;
	logic [4:0]  closes;
	logic [3:0]  err;
	logic        done;

	logic [3:0]  tp_err;
	logic [3:0]  hl;
	logic [63:0] acc_new;
	logic [3:0]  left_new;
	logic [31:0] pay_dec;
	logic        fin;
	logic [7:0]  ft;
	logic [63:0] fv;
	logic        cmpl;
	logic        extra;
	logic [CW-1:0] lim;

	assign in_rdy      = !tok_v_q || tok_ch.ready;
	assign in_ch.ready = in_rdy;
	assign fire        = in_ch.valid && in_rdy;
	assign b           = in_ch.in_byte;
	assign active      = in_ch.first_byte ||
		(phase_q == PH_TYPE) || (phase_q == PH_HDR) || (phase_q == PH_PAY);
	assign ph_eff      = in_ch.first_byte ? PH_TYPE : phase_q;
	assign acc_new     = {acc_q[55:0], b};
	assign left_new    = left_q - 4'd1;
	assign pay_dec     = pay_q - 32'd1;
	assign hl          = header_len(b);
	assign lim = (CW'(depth_limit_q) > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(depth_limit_q);

	mst_stack #(.MAX_DEPTH(MAX_DEPTH), .SPW(SPW)) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sp       (sp_eff),
		.sp_next  (sp_next),
		.casc_sp  (casc_sp),
		.key_slot (key_slot)
	);

	// type byte checks, by slot: top level, map key, ordinary value
	always_comb begin
		tp_err = E_NONE;
		if (sp_eff == '0) begin
			if (!is_container(b))
				tp_err = E_TOP;
		end else if (key_slot) begin
			if (is_wide_str(b)) begin
				if (!wide_keys_q)
					tp_err = E_WIDE;
			end else if (!key_ok(b)) begin
				tp_err = E_KEY;
			end
		end else if (!supported(b)) begin
			tp_err = E_VAL;
		end
	end

	always_comb begin
		emit    = 1'b0;
		kind    = TK_ERROR;
		val     = '0;
		key     = key_slot;
		lvl     = 5'(sp_eff);
		closes  = '0;
		err     = E_NONE;
		done    = 1'b0;
		fin     = 1'b0;
		cmpl    = 1'b0;
		extra   = 1'b0;
		phase_n = phase_q;
		acc_n   = acc_q;
		left_n  = left_q;
		ptype_n = ptype_q;
		pay_n   = pay_q;
		cmd     = '0;
		cmd.clear = fire && in_ch.first_byte;
		ft      = (ph_eff == PH_TYPE) ? b : ptype_q;
		fv      = acc_new;
		if (ph_eff == PH_TYPE) begin
			if (b inside {[8'h80:8'h9f]})
				fv = {60'd0, b[3:0]};
			else if (b inside {[8'ha0:8'hbf]})
				fv = {59'd0, b[4:0]};
			else
				fv = {56'd0, b};
		end

		if (fire && active) begin
			if (in_ch.first_byte)
				phase_n = PH_TYPE;
			case (ph_eff)
				PH_TYPE: begin
					if (tp_err != E_NONE) begin
						err = tp_err;
					end else if (hl != 4'd0) begin
						ptype_n = b;
						left_n  = hl;
						acc_n   = '0;
						phase_n = PH_HDR;
					end else begin
						fin = 1'b1;
					end
				end
				PH_HDR: begin
					acc_n  = acc_new;
					left_n = left_new;
					if (left_new == 4'd0)
						fin = 1'b1;
				end
				PH_PAY: begin
					pay_n = pay_dec;
					emit  = 1'b1;
					kind  = TK_PAY;
					val   = {56'd0, b};
					if (pay_dec == 32'd0)
						cmpl = 1'b1;
				end
				default: ;
			endcase

			if (fin) begin
				emit = 1'b1;
				if (is_container(ft)) begin
					kind = (ft inside {[8'h80:8'h8f], 8'hde, 8'hdf}) ? TK_MAP : TK_ARRAY;
					if ((CW'(sp_eff) + CW'(1)) >= lim) begin
						err = E_DEEP;
					end else if (fv[31:0] == 32'd0) begin
						cmpl  = 1'b1;
						extra = 1'b1;
					end else begin
						val          = {32'd0, fv[31:0]};
						cmd.push     = 1'b1;
						cmd.push_map = (kind == TK_MAP);
						cmd.push_cnt = (kind == TK_MAP) ? {fv[31:0], 1'b0} : {1'b0, fv[31:0]};
						phase_n      = PH_TYPE;
					end
				end else if (ft inside {[8'ha0:8'hbf], [8'hc4:8'hc6], [8'hd9:8'hdb]}) begin
					kind = (ft inside {[8'hc4:8'hc6]}) ? TK_BIN : TK_STR;
					if (is_wide_str(ft) && cap_str_q && (fv[31:24] != 8'd0)) begin
						err = E_STRLEN;
					end else if (fv[31:0] == 32'd0) begin
						cmpl = 1'b1;
					end else begin
						val     = {32'd0, fv[31:0]};
						pay_n   = fv[31:0];
						phase_n = PH_PAY;
					end
				end else if (ft == 8'hca) begin
					kind = TK_F32;
					val  = {32'd0, fv[31:0]};
					if (fv[30:23] == 8'hff)
						err = E_NAN;
					else
						cmpl = 1'b1;
				end else if (ft == 8'hcb) begin
					kind = TK_F64;
					val  = fv;
					if (fv[62:52] == 11'h7ff)
						err = E_NAN;
					else
						cmpl = 1'b1;
				end else if (ft inside {[8'hcc:8'hcf]}) begin
					kind = TK_UINT;
					val  = fv;
					cmpl = 1'b1;
				end else if (ft inside {[8'hd0:8'hd3]}) begin
					kind = TK_INT;
					cmpl = 1'b1;
					case (ft[1:0])
						2'd0:    val = {{56{fv[7]}}, fv[7:0]};
						2'd1:    val = {{48{fv[15]}}, fv[15:0]};
						2'd2:    val = {{32{fv[31]}}, fv[31:0]};
						default: val = fv;
					endcase
				end else if (ft == 8'hc0) begin
					kind = TK_NIL;
					cmpl = 1'b1;
				end else if (ft == 8'hc2 || ft == 8'hc3) begin
					kind = TK_BOOL;
					val  = {63'd0, ft[0]};
					cmpl = 1'b1;
				end else if (ft <= 8'h7f) begin
					kind = TK_UINT;
					val  = {56'd0, ft};
					cmpl = 1'b1;
				end else begin
					// negative fixint, 0xe0 included
					kind = TK_INT;
					val  = {56'hff_ffff_ffff_ffff, ft};
					cmpl = 1'b1;
				end
			end

			if (cmpl) begin
				cmd.complete = 1'b1;
				closes  = 5'(({1'b0, sp_eff} - {1'b0, casc_sp}) + (SPW+1)'(extra));
				done    = (casc_sp == '0);
				phase_n = done ? PH_DONE : PH_TYPE;
			end

			if (err != E_NONE) begin
				emit    = 1'b1;
				phase_n = PH_ERR;
			end else if (in_ch.last_byte &&
				(phase_n == PH_TYPE || phase_n == PH_HDR || phase_n == PH_PAY)) begin
				// buffer ended with the message still open
				emit    = 1'b1;
				err     = E_EARLY;
				lvl     = 5'(sp_next);
				phase_n = PH_ERR;
			end

			if (err != E_NONE) begin
				kind   = TK_ERROR;
				val    = '0;
				key    = 1'b0;
				closes = '0;
				done   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= 5'd16;
			wide_keys_q   <= 1'b0;
			cap_str_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEPTH_LIMIT: depth_limit_q <= cfg_data;
				CFG_WIDE_KEYS:   wide_keys_q   <= cfg_data[0];
				CFG_CAP_STR:     cap_str_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			acc_q    <= '0;
			left_q   <= '0;
			ptype_q  <= '0;
			pay_q    <= '0;
			tok_v_q  <= 1'b0;
			kind_q   <= '0;
			val_q    <= '0;
			key_q    <= 1'b0;
			lvl_q    <= '0;
			closes_q <= '0;
			err_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			ptype_q <= ptype_n;
			pay_q   <= pay_n;
			if (in_rdy) begin
				tok_v_q <= emit;
				if (emit) begin
					kind_q   <= kind;
					val_q    <= val;
					key_q    <= key;
					lvl_q    <= lvl;
					closes_q <= closes;
					err_q    <= err;
					done_q   <= done;
				end
			end
		end
	end

	assign tok_ch.valid        = tok_v_q;
	assign tok_ch.token_kind   = kind_q;
	assign tok_ch.token_value  = val_q;
	assign tok_ch.in_key_slot  = key_q;
	assign tok_ch.nest_level   = lvl_q;
	assign tok_ch.closes_after = closes_q;
	assign tok_ch.error_code   = err_q;
	assign tok_ch.message_done = done_q;
endmodule
`default_nettype wire

/* rtl/mst_checker.sv */
// Port-level checks on the token channel of the tokeniser, bound to the top level.
// Depends on mst_pkg and msgpack_stream_tokenizer.
`default_nettype none
module mst_checker import mst_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        tok_valid,
	input wire logic        tok_ready,
	input wire logic [3:0]  token_kind,
	input wire logic [63:0] token_value,
	input wire logic        in_key_slot,
	input wire logic [4:0]  closes_after,
	input wire logic [3:0]  error_code,
	input wire logic        message_done
);
	a_err_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && token_kind == TK_ERROR) |->
		(error_code != E_NONE && closes_after == 5'd0 && !message_done && !in_key_slot &&
		 token_value == 64'd0))
		else $error("error token carries completion or value fields");

	a_ok_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && token_kind != TK_ERROR) |-> (error_code == E_NONE))
		else $error("non-error token carries an error code");

	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && message_done) |-> (closes_after != 5'd0))
		else $error("message done without any container closing");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && !tok_ready) |=> (tok_valid && $stable(token_value) &&
		 $stable(token_kind)))
		else $error("stalled token changed");
endmodule

bind msgpack_stream_tokenizer mst_checker u_mst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tok_valid    (tok_ch.valid),
	.tok_ready    (tok_ch.ready),
	.token_kind   (tok_ch.token_kind),
	.token_value  (tok_ch.token_value),
	.in_key_slot  (tok_ch.in_key_slot),
	.closes_after (tok_ch.closes_after),
	.error_code   (tok_ch.error_code),
	.message_done (tok_ch.message_done)
);
`default_nettype wire

/* dv/tb_msgpack_stream_tokenizer.sv */
// Self-checking testbench for msgpack_stream_tokenizer: byte-level stimulus, token checking.
// Depends on mst_pkg, mst_if (mst_in_if, mst_tok_if) and the RTL top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_msgpack_stream_tokenizer;
	import mst_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [33:0] MAP_BIT = 34'h200000000;
	localparam logic [32:0] CNT_ONES = 33'h1FFFFFFFF;

	// parser phases of the predictor
	typedef enum logic [2:0] {PH_IDLE, PH_TYPE, PH_HDR, PH_PAY, PH_DONE, PH_ERR} phase_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic        key;
		logic [4:0]  level;
		logic [4:0]  closes;
		logic [3:0]  err;
		logic        done;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_DEPTH_LIMIT;
	logic [4:0] cfg_data = '0;

	mst_in_if  in_ch();
	mst_tok_if tok_ch();

	msgpack_stream_tokenizer DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .tok_ch(tok_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// idle/stall odds in percent, and a long receiver hold-off
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_cycles = 0;

	// predictor state
	logic [4:0]  lim_reg = 5'd16;
	logic        wide_keys = 1'b0;
	logic        cap_len = 1'b1;
	logic [33:0] open_counts [DEPTH];
	logic [4:0]  depth_ptr;
	logic [63:0] hdr_acc;
	logic [3:0]  hdr_left;
	logic [7:0]  hdr_type;
	logic [31:0] pay_left;
	phase_t      phase;

	token_t expected_tokens[$];
	int unsigned n_tokens = 0, n_bytes = 0, n_errors = 0, n_fail = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.first_byte = 1'b0;
		in_ch.last_byte = 1'b0;
		tok_ch.ready = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic logic container_code(input logic [7:0] t);
		return (t >= 8'h80 && t <= 8'h9f) || (t >= 8'hdc && t <= 8'hdf);
	endfunction

	function automatic logic wide_code(input logic [7:0] t);
		return t == 8'hc6 || t == 8'hdb;
	endfunction

	function automatic logic key_code(input logic [7:0] t);
		return t <= 8'h7f || t >= 8'he0 || (t >= 8'ha0 && t <= 8'hbf) ||
			t == 8'hc4 || t == 8'hc5 || t == 8'hd9 || t == 8'hda ||
			(t >= 8'hca && t <= 8'hcf);
	endfunction

	function automatic logic handled_code(input logic [7:0] t);
		return !(t == 8'hc1 || (t >= 8'hc7 && t <= 8'hc9) || (t >= 8'hd4 && t <= 8'hd8));
	endfunction

	function automatic logic [3:0] hdr_bytes(input logic [7:0] t);
		case (t)
			8'hc4, 8'hd9: return 4'd1;
			8'hc5, 8'hda, 8'hdc, 8'hde: return 4'd2;
			8'hc6, 8'hdb, 8'hdd, 8'hdf, 8'hca: return 4'd4;
			8'hcb: return 4'd8;
			8'hcc, 8'hd0: return 4'd1;
			8'hcd, 8'hd1: return 4'd2;
			8'hce, 8'hd2: return 4'd4;
			8'hcf, 8'hd3: return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic at_key();
		logic [33:0] top;
		if (depth_ptr == 0)
			return 1'b0;
		top = open_counts[depth_ptr - 1];
		return top[33] && !top[0];
	endfunction

	function automatic token_t error_token(input logic [3:0] code);
		token_t t;
		t = '{kind: TK_ERROR, value: '0, key: 1'b0, level: depth_ptr, closes: '0,
			err: code, done: 1'b0};
		phase = PH_ERR;
		return t;
	endfunction

	// one element finished at the current level: count down, pop what empties
	function automatic token_t closing_token(input logic [3:0] kind, input logic [63:0] v,
			input logic key, input logic [4:0] lvl, input logic [4:0] extra);
		token_t t;
		logic [32:0] c;
		logic [4:0] n;
		n = extra;
		while (depth_ptr > 0) begin
			c = (open_counts[depth_ptr - 1][32:0] - 33'd1) & CNT_ONES;
			open_counts[depth_ptr - 1] = {open_counts[depth_ptr - 1][33], c};
			if (c != 0)
				break;
			depth_ptr--;
			n++;
		end
		phase = (depth_ptr == 0) ? PH_DONE : PH_TYPE;
		t = '{kind: kind, value: v, key: key, level: lvl, closes: n, err: E_NONE,
			done: depth_ptr == 0};
		return t;
	endfunction

	function automatic token_t finish_item(input logic [7:0] t, input logic [63:0] v);
		logic key;
		logic [4:0] lvl, lim;
		logic is_map;
		logic [3:0] kind;
		logic [31:0] cnt;
		int bits;
		key = at_key();
		lvl = depth_ptr;
		cnt = v[31:0];
		if (container_code(t)) begin
			is_map = (t >= 8'h80 && t <= 8'h8f) || t == 8'hde || t == 8'hdf;
			kind = is_map ? TK_MAP : TK_ARRAY;
			lim = (lim_reg > DEPTH) ? 5'(DEPTH) : lim_reg;
			if (32'(depth_ptr) + 1 >= 32'(lim))
				return error_token(E_DEEP);
			if (cnt == 0)
				return closing_token(kind, '0, key, lvl, 5'd1);
			open_counts[depth_ptr] = is_map ? (MAP_BIT | {1'b0, cnt, 1'b0}) : 34'(cnt);
			depth_ptr++;
			phase = PH_TYPE;
			return '{kind: kind, value: 64'(cnt), key: key, level: lvl, closes: '0,
				err: E_NONE, done: 1'b0};
		end
		if ((t >= 8'ha0 && t <= 8'hbf) || (t >= 8'hc4 && t <= 8'hc6) ||
				(t >= 8'hd9 && t <= 8'hdb)) begin
			kind = (t >= 8'hc4 && t <= 8'hc6) ? TK_BIN : TK_STR;
			if (wide_code(t) && cap_len && cnt >= 32'd16777216)
				return error_token(E_STRLEN);
			if (cnt == 0)
				return closing_token(kind, '0, key, lvl, '0);
			pay_left = cnt;
			phase = PH_PAY;
			return '{kind: kind, value: 64'(cnt), key: key, level: lvl, closes: '0,
				err: E_NONE, done: 1'b0};
		end
		if (t == 8'hca) begin
			if (v[30:23] == 8'hff)
				return error_token(E_NAN);
			return closing_token(TK_F32, {32'd0, v[31:0]}, key, lvl, '0);
		end
		if (t == 8'hcb) begin
			if (v[62:52] == 11'h7ff)
				return error_token(E_NAN);
			return closing_token(TK_F64, v, key, lvl, '0);
		end
		if (t >= 8'hcc && t <= 8'hcf)
			return closing_token(TK_UINT, v, key, lvl, '0);
		if (t >= 8'hd0 && t <= 8'hd3) begin
			bits = 8 << t[1:0];
			if (bits < 64 && v[bits - 1])
				v |= ~((64'd1 << bits) - 64'd1);
			return closing_token(TK_INT, v, key, lvl, '0);
		end
		if (t == 8'hc0)
			return closing_token(TK_NIL, '0, key, lvl, '0);
		if (t == 8'hc2 || t == 8'hc3)
			return closing_token(TK_BOOL, 64'(t[0]), key, lvl, '0);
		if (t <= 8'h7f)
			return closing_token(TK_UINT, 64'(t), key, lvl, '0);
		return closing_token(TK_INT, {56'hFFFFFFFFFFFFFF, t}, key, lvl, '0);
	endfunction

	// returns 1 with tok set when the byte gives a token
	function automatic logic predict_byte(input logic [7:0] b, input logic first,
			input logic last, output token_t tok);
		logic hit;
		logic [3:0] hl;
		logic [63:0] fixv;
		hit = 1'b0;
		tok = '0;
		if (first) begin
			depth_ptr = '0;
			hdr_acc = '0;
			hdr_left = '0;
			hdr_type = '0;
			pay_left = '0;
			phase = PH_TYPE;
		end else if (phase != PH_TYPE && phase != PH_HDR && phase != PH_PAY)
			return 1'b0;
		if (phase == PH_TYPE) begin
			hit = 1'b1;
			if (depth_ptr == 0 && !container_code(b))
				tok = error_token(E_TOP);
			else if (depth_ptr != 0 && at_key() && wide_code(b) && !wide_keys)
				tok = error_token(E_WIDE);
			else if (depth_ptr != 0 && at_key() && !wide_code(b) && !key_code(b))
				tok = error_token(E_KEY);
			else if (depth_ptr != 0 && !at_key() && !handled_code(b))
				tok = error_token(E_VAL);
			else begin
				hl = hdr_bytes(b);
				if (hl != 0) begin
					hdr_type = b;
					hdr_left = hl;
					hdr_acc = '0;
					phase = PH_HDR;
					hit = 1'b0;
				end else begin
					if (b >= 8'h80 && b <= 8'h9f)
						fixv = 64'(b[3:0]);
					else if (b >= 8'ha0 && b <= 8'hbf)
						fixv = 64'(b[4:0]);
					else
						fixv = 64'(b);
					tok = finish_item(b, fixv);
				end
			end
		end else if (phase == PH_HDR) begin
			hdr_acc = {hdr_acc[55:0], b};
			hdr_left--;
			if (hdr_left == 0) begin
				tok = finish_item(hdr_type, hdr_acc);
				hit = 1'b1;
			end
		end else begin
			pay_left--;
			hit = 1'b1;
			if (pay_left == 0)
				tok = closing_token(TK_PAY, 64'(b), at_key(), depth_ptr, '0);
			else
				tok = '{kind: TK_PAY, value: 64'(b), key: at_key(), level: depth_ptr,
					closes: '0, err: E_NONE, done: 1'b0};
		end
		if (last && (phase == PH_TYPE || phase == PH_HDR || phase == PH_PAY)) begin
			tok = error_token(E_EARLY);
			hit = 1'b1;
		end
		return hit;
	endfunction

	// ---------------- driving ----------------
	// sends one byte; valid stays high across back-to-back transactions
	task automatic send_byte(input logic [7:0] b, input logic first = 1'b0,
			input logic last = 1'b0);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.first_byte <= first;
		in_ch.last_byte <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic send_bytes(input logic [7:0] bytes[$], input logic end_mark = 1'b1);
		foreach (bytes[i])
			send_byte(bytes[i], i == 0, end_mark && i == bytes.size() - 1);
	endtask

	// prediction is made on acceptance so that it follows the exact transaction order
	always @(posedge clk) begin
		token_t tok;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			n_bytes++;
			if (predict_byte(in_ch.in_byte, in_ch.first_byte, in_ch.last_byte, tok))
				expected_tokens.push_back(tok);
		end
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			tok_ch.ready <= 1'b0;
		end else
			tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------- checking ----------------
	always @(posedge clk) begin
		token_t got, want;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			got = '{kind: tok_ch.token_kind, value: tok_ch.token_value,
				key: tok_ch.in_key_slot, level: tok_ch.nest_level,
				closes: tok_ch.closes_after, err: tok_ch.error_code,
				done: tok_ch.message_done};
			n_tokens++;
			if (got.kind == TK_ERROR)
				n_errors++;
			if (expected_tokens.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected token: kind %0d value %h err %0d", got.kind,
						got.value, got.err);
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want) begin
					n_fail++;
					if (n_fail <= 10)
						$display("token mismatch: want k%0d v%h key%0d lvl%0d cl%0d e%0d d%0d, got k%0d v%h key%0d lvl%0d cl%0d e%0d d%0d",
							want.kind, want.value, want.key, want.level, want.closes,
							want.err, want.done, got.kind, got.value, got.key,
							got.level, got.closes, got.err, got.done);
				end
			end
		end
	end

	// stop sending, wait for outstanding tokens, then wait out the output register
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEPTH_LIMIT: lim_reg = val;
			CFG_WIDE_KEYS:   wide_keys = val[0];
			default:         cap_len = val[0];
		endcase
	endtask

	// ---------------- random message builder ----------------
	function automatic void push_be(ref logic [7:0] q[$], input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			q.push_back(v[8*i +: 8]);
	endfunction

	// short random payload sizes keep messages brief
	function automatic void add_str(ref logic [7:0] q[$], input logic as_key);
		int len, pick;
		len = $urandom_range(0, 4);
		pick = $urandom_range(0, as_key ? 4 : 5);
		case (pick)
			0: q.push_back(8'ha0 | 8'(len));
			1: begin q.push_back(8'hd9); q.push_back(8'(len)); end
			2: begin q.push_back(8'hda); push_be(q, 64'(len), 2); end
			3: begin q.push_back(8'hc4); q.push_back(8'(len)); end
			4: begin q.push_back(8'hc5); push_be(q, 64'(len), 2); end
			default: begin
				q.push_back($urandom_range(1) ? 8'hdb : 8'hc6);
				push_be(q, 64'(len), 4);
			end
		endcase
		repeat (len) q.push_back(8'($urandom));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void add_scalar(ref logic [7:0] q[$]);
		logic [7:0] t;
		case ($urandom_range(0, 9))
			0: q.push_back(8'($urandom_range(0, 8'h7f)));
			1: q.push_back(8'($urandom_range(8'he0, 8'hff)));
			2: q.push_back(8'($urandom_range(8'hc0, 8'hc3)) | 8'h00);
			3: begin t = 8'($urandom_range(8'hcc, 8'hd3)); q.push_back(t);
				push_be(q, rand64(), hdr_bytes(t)); end
			4: begin q.push_back(8'hca); push_be(q, rand64(), 4); end
			5: begin q.push_back(8'hcb); push_be(q, rand64(), 8); end
			default: add_str(q, 1'b0);
		endcase
	endfunction

	function automatic void add_key(ref logic [7:0] q[$]);
		case ($urandom_range(0, 3))
			0: q.push_back(8'($urandom_range(0, 8'h7f)));
			1: q.push_back(8'($urandom_range(8'he0, 8'hff)));
			2: begin q.push_back(8'($urandom_range(8'hcc, 8'hcf))); push_be(q, rand64(), 8); end
			default: add_str(q, 1'b1);
		endcase
	endfunction

	function automatic void add_value(ref logic [7:0] q[$], input int lvl);
		int n;
		logic is_map;
		if (lvl < 5 && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(0, 3);
			is_map = $urandom_range(1);
			case ($urandom_range(0, 2))
				0: q.push_back((is_map ? 8'h80 : 8'h90) | 8'(n));
				1: begin q.push_back(is_map ? 8'hde : 8'hdc); push_be(q, 64'(n), 2); end
				default: begin q.push_back(is_map ? 8'hdf : 8'hdd); push_be(q, 64'(n), 4); end
			endcase
			repeat (n) begin
				if (is_map)
					add_key(q);
				add_value(q, lvl + 1);
			end
		end else
			add_scalar(q);
	endfunction

	function automatic void build_message(ref logic [7:0] q[$]);
		int n;
		logic is_map;
		q = {};
		n = $urandom_range(1, 4);
		is_map = $urandom_range(1);
		q.push_back((is_map ? 8'h80 : 8'h90) | 8'(n));
		repeat (n) begin
			if (is_map)
				add_key(q);
			add_value(q, 1);
		end
		// occasional corruption: a random byte or a truncation
		case ($urandom_range(0, 9))
			0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
			1: if (q.size() > 2) q = q[0:$urandom_range(1, q.size() - 2)];
			default: ;
		endcase
	endfunction

	task automatic random_messages(input int unsigned nbytes);
		logic [7:0] q[$];
		int unsigned sent;
		sent = 0;
		while (sent < nbytes) begin
			build_message(q);
			// last_byte mostly marks the real end; sometimes the buffer carries on
			send_bytes(q, $urandom_range(0, 4) != 0);
			if ($urandom_range(0, 7) == 0)
				send_byte(8'($urandom), 1'b0, $urandom_range(1));
			sent += q.size();
		end
	endtask

	// ---------------- tests ----------------
	task automatic test_directed_scalars();
		// map key types, negative fixint at the boundary, signed ints, nil, booleans, floats
		send_bytes('{8'h86, 8'h7f, 8'he0, 8'he0, 8'hd0, 8'h80, 8'hcf, 8'hff, 8'hff, 8'hff,
			8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hd3, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00});
		send_bytes('{8'h95, 8'hc0, 8'hc2, 8'hc3, 8'hca, 8'h3f, 8'h80, 8'h00, 8'h00,
			8'hcb, 8'h40, 8'h09, 8'h21, 8'hfb, 8'h54, 8'h44, 8'h2d, 8'h18});
	endtask

	task automatic test_errors();
		send_bytes('{8'hc0});                               // scalar at top
		send_bytes('{8'h91, 8'hc1});                        // never-used code
		send_bytes('{8'h91, 8'hd4, 8'h00});                 // ext type as value
		send_bytes('{8'h81, 8'hc0});                        // nil as key
		send_bytes('{8'h81, 8'hdb, 8'h00, 8'h00, 8'h00, 8'h01});  // wide key
		send_bytes('{8'h91, 8'hca, 8'h7f, 8'h80, 8'h00, 8'h00});  // Inf
		send_bytes('{8'h91, 8'hcb, 8'hff, 8'hf8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00});                                        // NaN
		send_bytes('{8'h91, 8'hc6, 8'h01, 8'h00, 8'h00, 8'h00});  // length cap
		send_bytes('{8'h92, 8'h01});                        // early end
		send_byte(8'h33);                                   // ignored after error
		send_bytes('{8'h91, 8'h91, 8'h91, 8'h90});          // nested, closes cascade
		send_bytes('{8'h91, 8'ha2, 8'h41}, 1'b0);           // cut short, no last mark: no early-end error
		send_bytes('{8'h80});                               // empty top map
	endtask

	task automatic test_config();
		write_cfg(CFG_WIDE_KEYS, 5'd1);
		write_cfg(CFG_CAP_STR, 5'd0);
		send_bytes('{8'h81, 8'hc6, 8'h00, 8'h00, 8'h00, 8'h01, 8'h5a, 8'h01});
		send_bytes('{8'h91, 8'hdb, 8'hff, 8'h00, 8'h00, 8'h00, 8'h41}); // huge, then ends
		write_cfg(CFG_DEPTH_LIMIT, 5'd0);
		send_bytes('{8'h90});
		write_cfg(CFG_DEPTH_LIMIT, 5'd1);
		send_bytes('{8'h91, 8'h01});
		write_cfg(CFG_DEPTH_LIMIT, 5'd2);
		send_bytes('{8'h91, 8'h91, 8'h01});
		write_cfg(CFG_DEPTH_LIMIT, 5'd31);
		begin
			logic [7:0] deep[$];
			repeat (16) deep.push_back(8'h91);
			deep.push_back(8'h01);
			send_bytes(deep);
		end
	endtask

	task automatic test_random_phase(input int unsigned sidle, input int unsigned rstall,
			input int unsigned nbytes);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		random_messages(nbytes);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		hold_cycles = 60;
		random_messages(40);
	endtask

	task automatic test_random_config();
		write_cfg(CFG_DEPTH_LIMIT, 5'($urandom_range(3, 16)));
		write_cfg(CFG_WIDE_KEYS, 5'($urandom_range(1)));
		write_cfg(CFG_CAP_STR, 5'd1);
		test_random_phase(31, 31, 200);
	endtask

	// watchdog
	initial begin
		#20ms;
		$display("** msgpack_stream_tokenizer: FAILED **");
		$finish;
	end

	initial begin
		depth_ptr = '0;
		phase = PH_IDLE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_byte(8'h01);            // before any first byte: ignored
		test_directed_scalars();
		test_errors();
		test_config();
		write_cfg(CFG_DEPTH_LIMIT, 5'd16);
		write_cfg(CFG_WIDE_KEYS, 5'd0);
		write_cfg(CFG_CAP_STR, 5'd1);
		test_random_phase(0, 0, 250);
		test_random_phase(53, 0, 250);
		test_random_phase(0, 53, 250);
		test_backpressure();
		test_random_config();
		drain();
		$display("Sent %0d bytes; checked %0d tokens, %0d of them errors.",
			n_bytes, n_tokens, n_errors);
		if (n_fail == 0)
			$display("** msgpack_stream_tokenizer: PASSED **");
		else
			$display("** msgpack_stream_tokenizer: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
